// ===== design/clipped_color_key_blit_assert.svh =====
// assertion macros shared by the blit block
`ifndef CLIPPED_COLOR_KEY_BLIT_ASSERT_SVH
`define CLIPPED_COLOR_KEY_BLIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CKB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CKB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ckb_pkg.sv =====
`timescale 1ns / 1ps

package ckb_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PLACE_X       = 3'd0,
    REG_PLACE_Y       = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_KEY_ENABLE    = 3'd6,
    REG_KEY_COLOR     = 3'd7
  } cfg_reg_t;

  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned DimBits      = 13;
  localparam int unsigned CoordBits    = 14;
  localparam int unsigned WordBits     = 32;

  localparam logic [DimBits-1:0] RectWidthReset    = 13'd1;
  localparam logic [DimBits-1:0] RectHeightReset   = 13'd1;
  localparam logic [DimBits-1:0] ScreenWidthReset  = 13'd640;
  localparam logic [DimBits-1:0] ScreenHeightReset = 13'd480;

  typedef struct packed {
    logic signed [DimBits-1:0] place_x;
    logic signed [DimBits-1:0] place_y;
    logic [DimBits-1:0]        rect_width;
    logic [DimBits-1:0]        rect_height;
    logic [DimBits-1:0]        screen_width;
    logic [DimBits-1:0]        screen_height;
    logic                      key_enable;
    logic [WordBits-1:0]       key_color;
  } ckb_cfg_t;

endpackage

// ===== design/ckb_pos.sv =====
`timescale 1ns / 1ps

module ckb_pos import ckb_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [DimBits-1:0]          rect_width,
  input  logic [DimBits-1:0]          rect_height,
  output logic [$clog2(MAX_DIM)-1:0]  col,
  output logic [$clog2(MAX_DIM)-1:0]  row,
  output logic                        last
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = (CW + 1 > DimBits + 1) ? CW + 1 : DimBits + 1;
  localparam logic [DW-1:0] MaxDim = DW'(MAX_DIM);

  logic [DW-1:0] w_ext, h_ext, w_m1, h_m1, col_ext, row_ext;
  logic          row_end;
  logic [CW-1:0] col_next, row_next;

  assign w_ext   = {{(DW-DimBits){1'b0}}, rect_width};
  assign h_ext   = {{(DW-DimBits){1'b0}}, rect_height};
  assign col_ext = {{(DW-CW){1'b0}}, col};
  assign row_ext = {{(DW-CW){1'b0}}, row};

  // size clamped to 1..MAX_DIM, minus one
  always_comb begin
    if (w_ext == '0) begin
      w_m1 = '0;
    end else if (w_ext > MaxDim) begin
      w_m1 = MaxDim - 1'b1;
    end else begin
      w_m1 = w_ext - 1'b1;
    end
    if (h_ext == '0) begin
      h_m1 = '0;
    end else if (h_ext > MaxDim) begin
      h_m1 = MaxDim - 1'b1;
    end else begin
      h_m1 = h_ext - 1'b1;
    end
  end

  // at or past the last column ends the row, even after a size change
  assign row_end = col_ext >= w_m1;
  assign last    = row_end && (row_ext >= h_m1);

  always_comb begin
    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (row_end) begin
      col_next = '0;
      row_next = row + 1'b1;
    end else begin
      col_next = col + 1'b1;
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

// ===== design/ckb_eval.sv =====
`timescale 1ns / 1ps

module ckb_eval import ckb_pkg::*; #(
  parameter int unsigned MAX_DIM    = 4096,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  ckb_cfg_t                    cfg,
  input  logic [$clog2(MAX_DIM)-1:0]  col,
  input  logic [$clog2(MAX_DIM)-1:0]  row,
  input  logic [WordBits-1:0]         pixel,
  output logic [CoordBits-1:0]        x,
  output logic [CoordBits-1:0]        y,
  output logic [WordBits-1:0]         pixel_kept,
  output logic                        write_en
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned XW = ((CW > DimBits) ? CW : DimBits) + 2;
  localparam logic [WordBits-1:0] PixMask =
    (PIXEL_BITS >= WordBits) ? {WordBits{1'b1}} :
                               ((WordBits'(1) << PIXEL_BITS) - 1'b1);

  logic signed [XW-1:0] x_full, y_full;
  logic [XW-1:0]        sw_ext, sh_ext;
  logic                 on_screen, keyed;

  assign x_full = $signed({{(XW-DimBits){cfg.place_x[DimBits-1]}}, cfg.place_x})
                + $signed({{(XW-CW){1'b0}}, col});
  assign y_full = $signed({{(XW-DimBits){cfg.place_y[DimBits-1]}}, cfg.place_y})
                + $signed({{(XW-CW){1'b0}}, row});
  assign sw_ext = {{(XW-DimBits){1'b0}}, cfg.screen_width};
  assign sh_ext = {{(XW-DimBits){1'b0}}, cfg.screen_height};

  // sign bit clear, then an unsigned compare against the screen size
  assign on_screen = !x_full[XW-1] && !y_full[XW-1]
                  && (XW'(x_full) < sw_ext) && (XW'(y_full) < sh_ext);

  assign pixel_kept = pixel & PixMask;
  // full-width key against the masked pixel
  assign keyed      = cfg.key_enable && (pixel_kept == cfg.key_color);
  assign write_en   = on_screen && !keyed;

  assign x = x_full[CoordBits-1:0];
  assign y = y_full[CoordBits-1:0];

endmodule

// ===== design/clipped_color_key_blit.sv =====
`timescale 1ns / 1ps
// clipped color-key blit: per-pixel destination coordinate and write enable
// input channel: in_valid / in_stall with pixel, one source pixel per request
//   in row-major order over the rectangle
// output channel: out_valid / out_stall with out_x, out_y, out_pixel,
//   write_en and last, one result per input request, in order
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
//   ready, write only while no request is in flight
// pipeline: the input stage loads on accept and the result register loads from
//   it whenever the result register is empty or being taken; throughput one
//   pixel per clock while out_stall is low, set by the two-stage register
//   pipeline
// stall: when out_stall holds a waiting result, the input stage still takes
//   one more request; in_stall rises only when both stages are full
// reset: synchronous rst empties both stages, zeroes the column and row
//   counters and loads the register defaults (640x480 screen, 1x1 rectangle,
//   keying off)
`include "clipped_color_key_blit_assert.svh"

module clipped_color_key_blit import ckb_pkg::*; #(
  parameter int unsigned MAX_DIM    = 4096,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  // pixel input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [WordBits-1:0]      pixel,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CoordBits-1:0] out_x,
  output logic signed [CoordBits-1:0] out_y,
  output logic [WordBits-1:0]      out_pixel,
  output logic                     write_en,
  output logic                     last,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexBits-1:0]  cfg_index,
  input  logic [WordBits-1:0]      cfg_data
);

  localparam int unsigned CW = $clog2(MAX_DIM);

  ckb_cfg_t cfg;

  // handshake
  logic accept, s1_adv;

  // input stage
  logic                s1_valid;
  logic [WordBits-1:0] s1_pixel;
  logic [CW-1:0]       s1_col, s1_row;
  logic                s1_last;

  // position counter
  logic [CW-1:0] pos_col, pos_row;
  logic          pos_last;

  // evaluation results
  logic [CoordBits-1:0] ev_x, ev_y;
  logic [WordBits-1:0]  ev_pixel;
  logic                 ev_we;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.place_x       <= '0;
      cfg.place_y       <= '0;
      cfg.rect_width    <= RectWidthReset;
      cfg.rect_height   <= RectHeightReset;
      cfg.screen_width  <= ScreenWidthReset;
      cfg.screen_height <= ScreenHeightReset;
      cfg.key_enable    <= 1'b0;
      cfg.key_color     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLACE_X:       cfg.place_x       <= cfg_data[DimBits-1:0];
        REG_PLACE_Y:       cfg.place_y       <= cfg_data[DimBits-1:0];
        REG_RECT_WIDTH:    cfg.rect_width    <= cfg_data[DimBits-1:0];
        REG_RECT_HEIGHT:   cfg.rect_height   <= cfg_data[DimBits-1:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[DimBits-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[DimBits-1:0];
        REG_KEY_ENABLE:    cfg.key_enable    <= cfg_data[0];
        REG_KEY_COLOR:     cfg.key_color     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // the result register moves when empty or being taken
  assign s1_adv   = !out_valid || !out_stall;
  // stall only when the input stage holds a request that cannot move
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // column/row tracking, stepped once per accepted pixel
  ckb_pos #(
    .MAX_DIM (MAX_DIM)
  ) u_pos (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .rect_width  (cfg.rect_width),
    .rect_height (cfg.rect_height),
    .col         (pos_col),
    .row         (pos_row),
    .last        (pos_last)
  );

  // input stage: pixel plus the position it belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_col   <= pos_col;
      s1_row   <= pos_row;
      s1_last  <= pos_last;
    end
  end

  // coordinate, clip and key test
  ckb_eval #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_eval (
    .cfg        (cfg),
    .col        (s1_col),
    .row        (s1_row),
    .pixel      (s1_pixel),
    .x          (ev_x),
    .y          (ev_y),
    .pixel_kept (ev_pixel),
    .write_en   (ev_we)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_x     <= ev_x;
      out_y     <= ev_y;
      out_pixel <= ev_pixel;
      write_en  <= ev_we;
      last      <= s1_last;
    end
  end

  // a pixel that ends the rectangle restarts the counters at the origin
  `CKB_ASSERT_NEXT(a_last_wraps, clk, rst, accept && pos_last,
    pos_col == '0 && pos_row == '0, "counters did not wrap after last pixel")

  // input stalls only behind a full input stage
  `CKB_ASSERT_NOW(a_stall_needs_full, clk, rst, in_stall,
    s1_valid && out_valid, "input stalled while a stage was free")

  // an enabled write always lands on a non-negative coordinate
  `CKB_ASSERT_NOW(a_write_on_screen, clk, rst, out_valid && write_en,
    !out_x[CoordBits-1] && !out_y[CoordBits-1], "write enabled off screen")

endmodule
